FILE: design/gdrc_pkg.sv
// Shared types, widths and constants of the grid DDA column ray caster.
package gdrc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 64;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 9;
	localparam int SHADE_W   = 8;

	localparam int DIV_NW    = 32;   // dividend and quotient width
	localparam int DIV_DW    = 40;   // divisor width
	localparam int DIV_CNT_W = 6;

	localparam int CAM_W     = 27;   // camera coordinate, Q.14 signed
	localparam int CAM_SH    = 22;   // reciprocal shift for the camera coordinate
	localparam int PROD_W    = 16 + CAM_W;
	localparam int RAY_W     = 30;   // ray component, Q.14 signed
	localparam int DELTA_W   = 32;   // step distance, Q.16
	localparam int DIST_W    = 40;   // side distance accumulators, Q.16
	localparam int CELL_W    = 5;    // map coordinate, two's complement
	localparam int MAP_IDX_W = 3;
	localparam int FRAC_W    = 13;
	localparam int CAM_ONE   = 16384;

	localparam logic [DELTA_W-1:0] DELTA_SAT = 32'h8000_0000;
	localparam logic [SHADE_W-1:0] SHADE_X   = 8'd255;
	localparam logic [SHADE_W-1:0] SHADE_Y   = 8'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X,
		REG_POS_Y,
		REG_DIR_X,
		REG_DIR_Y,
		REG_PLANE_X,
		REG_PLANE_Y,
		REG_MAP_WALLS
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] dir_x;
		logic [15:0] dir_y;
		logic [15:0] plane_x;
		logic [15:0] plane_y;
		logic [63:0] map_walls;
	} cfg_t;

	typedef enum logic [1:0] {
		DIV_DX,
		DIV_DY,
		DIV_LH
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CAM,
		S_RAY_MUL,
		S_RAY_ADD,
		S_DX_GO,
		S_DX_WAIT,
		S_DY_GO,
		S_DY_WAIT,
		S_SIDE,
		S_WALK,
		S_LH_GO,
		S_LH_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     load;
		logic     cam_calc;
		logic     div_start;
		div_sel_t div_sel;
		logic     ray_mul;
		logic     ray_add;
		logic     side_mul;
		logic     walk_step;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_end;
		logic hit;
	} sts_t;

endpackage

FILE: design/grid_dda_column_raycaster_core.sv
// Top level of the grid DDA column ray caster: config registers and core.
//
// One column is cast per transfer: raise start with column while busy is low.
// The camera coordinate comes from a constant reciprocal multiply, the ray is
// built from it and walked through the 8x8 wall map one cell per clock, and
// the wall stripe rows, side, shade and hit flag come back on done for exactly
// one clock; the receiver cannot stall, so it must take the result in that
// cycle. A single divider, retiring one quotient bit per clock, computes both
// step distances and, on a hit only, the stripe height. The walk gives up
// after MAX_STEPS cells without a wall. Busy drops with the strobe, so the
// next column can be accepted at the edge ending the strobe.
// Write the configuration registers only while busy is low; writes land at once.
module grid_dda_column_raycaster_core #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int MAP_SIZE      = 8,
	parameter int MAX_STEPS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gdrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gdrc_pkg::CFG_DW-1:0]       cfg_wdata,
	input  logic                              start,
	input  logic [gdrc_pkg::COL_W-1:0]        column,
	output logic                              busy,
	output logic                              done,
	output logic [gdrc_pkg::COL_W-1:0]        column_out,
	output logic [gdrc_pkg::ROW_W-1:0]        draw_start,
	output logic [gdrc_pkg::ROW_W-1:0]        draw_end,
	output logic                              wall_side,
	output logic [gdrc_pkg::SHADE_W-1:0]      wall_shade,
	output logic                              wall_found
);
	gdrc_pkg::cfg_t cfg_q;
	gdrc_pkg::cmd_t cmd;
	gdrc_pkg::sts_t sts;

	// config registers; indexes past the map word are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x     <= 16'd12288;
			cfg_q.pos_y     <= 16'd12288;
			cfg_q.dir_x     <= 16'd16384;
			cfg_q.dir_y     <= 16'd0;
			cfg_q.plane_x   <= 16'd0;
			cfg_q.plane_y   <= 16'd10813;
			cfg_q.map_walls <= 64'd18411205116194816511;
		end else if (cfg_we) begin
			case (gdrc_pkg::cfg_reg_t'(cfg_index))
				gdrc_pkg::REG_POS_X:     cfg_q.pos_x     <= cfg_wdata[15:0];
				gdrc_pkg::REG_POS_Y:     cfg_q.pos_y     <= cfg_wdata[15:0];
				gdrc_pkg::REG_DIR_X:     cfg_q.dir_x     <= cfg_wdata[15:0];
				gdrc_pkg::REG_DIR_Y:     cfg_q.dir_y     <= cfg_wdata[15:0];
				gdrc_pkg::REG_PLANE_X:   cfg_q.plane_x   <= cfg_wdata[15:0];
				gdrc_pkg::REG_PLANE_Y:   cfg_q.plane_y   <= cfg_wdata[15:0];
				gdrc_pkg::REG_MAP_WALLS: cfg_q.map_walls <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	gdrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic, walk and result registers
	gdrc_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.MAP_SIZE      (MAP_SIZE),
		.MAX_STEPS     (MAX_STEPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.column     (column),
		.sts        (sts),
		.done       (done),
		.column_out (column_out),
		.draw_start (draw_start),
		.draw_end   (draw_end),
		.wall_side  (wall_side),
		.wall_shade (wall_shade),
		.wall_found (wall_found)
	);
endmodule

FILE: design/gdrc_div.sv
// Restoring unsigned divider, one quotient bit per clock.
module gdrc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gdrc_pkg::DIV_NW-1:0]   dividend,
	input  logic [gdrc_pkg::DIV_DW-1:0]   divisor,
	output logic                          done,
	output logic [gdrc_pkg::DIV_NW-1:0]   quotient
);
	localparam int NW = gdrc_pkg::DIV_NW;
	localparam int DW = gdrc_pkg::DIV_DW;
	localparam int CW = gdrc_pkg::DIV_CNT_W;

	logic          active_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (active_q) begin
			rem_q <= ge ? DW'(shifted - {1'b0, dsr_q}) : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: design/gdrc_datapath.sv
// Ray caster datapath: camera and ray math, DDA walk, stripe height.
module gdrc_datapath #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int MAP_SIZE      = 8,
	parameter int MAX_STEPS     = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gdrc_pkg::cmd_t                 cmd,
	input  gdrc_pkg::cfg_t                 cfg,
	input  logic [gdrc_pkg::COL_W-1:0]     column,
	output gdrc_pkg::sts_t                 sts,
	output logic                           done,
	output logic [gdrc_pkg::COL_W-1:0]     column_out,
	output logic [gdrc_pkg::ROW_W-1:0]     draw_start,
	output logic [gdrc_pkg::ROW_W-1:0]     draw_end,
	output logic                           wall_side,
	output logic [gdrc_pkg::SHADE_W-1:0]   wall_shade,
	output logic                           wall_found
);
	localparam int NW     = gdrc_pkg::DIV_NW;
	localparam int DW     = gdrc_pkg::DIV_DW;
	localparam int CAM_W  = gdrc_pkg::CAM_W;
	localparam int CAM_SH = gdrc_pkg::CAM_SH;
	localparam int PROD_W = gdrc_pkg::PROD_W;
	localparam int RAY_W  = gdrc_pkg::RAY_W;
	localparam int DL_W   = gdrc_pkg::DELTA_W;
	localparam int DS_W   = gdrc_pkg::DIST_W;
	localparam int CELL_W = gdrc_pkg::CELL_W;
	localparam int FR_W   = gdrc_pkg::FRAC_W;
	localparam int MI_W   = gdrc_pkg::MAP_IDX_W;
	localparam int COL_W  = gdrc_pkg::COL_W;
	localparam int ROW_W  = gdrc_pkg::ROW_W;
	localparam int SP_W   = DL_W + FR_W + 1;
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int CP_W   = 48;

	localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS);
	localparam logic [NW-1:0]     LH_NUM     = NW'(SCREEN_HEIGHT) << 16;
	localparam logic [NW-1:0]     LH_FULL    = NW'(2 * SCREEN_HEIGHT);
	localparam logic [NW-1:0]     HALF_H     = NW'(SCREEN_HEIGHT / 2);
	localparam logic [NW-1:0]     ROWS       = NW'(SCREEN_HEIGHT);
	localparam logic [NW-1:0]     LAST_ROW   = NW'(SCREEN_HEIGHT - 1);
	localparam logic [NW-1:0]     RECIP_NUM  = NW'(1) << 30;
	// col * 2^15 / width as col * ceil(2^37 / width) >> 22, exact for 10-bit col
	localparam logic [CP_W-1:0]   CAM_MUL    = CP_W'(((64'd1 << (15 + CAM_SH))
		+ 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

	logic [COL_W-1:0]         col_q;
	logic [CAM_W-1:0]         cam_q;
	logic signed [PROD_W-1:0] prodx_q, prody_q;
	logic signed [RAY_W-1:0]  rx_q, ry_q;
	logic [DL_W-1:0]          dx_q, dy_q;
	logic [DS_W-1:0]          sdx_q, sdy_q;
	logic [CELL_W-1:0]        mx_q, my_q;
	logic                     negx_q, negy_q;
	logic [STEP_W-1:0]        n_q;
	logic                     side_q;
	logic [NW-1:0]            lh_q;
	logic                     done_q;

	logic [CP_W-1:0]  cam_prod;
	logic [RAY_W-1:0] rx_abs, ry_abs;
	logic [DS_W-1:0]  perp;
	logic [NW-1:0]    div_num;
	logic [DW-1:0]    div_den;
	logic             div_done;
	logic [NW-1:0]    quot;
	logic [FR_W:0]    opx, opy;
	logic [SP_W-1:0]  spx, spy;
	logic             off_map;
	logic             hit_c;
	logic [NW-1:0]    half, ds_c, de_c, de_sum;

	assign cam_prod = CP_W'(col_q) * CAM_MUL;

	assign rx_abs = rx_q[RAY_W-1] ? RAY_W'(0) - $unsigned(rx_q) : $unsigned(rx_q);
	assign ry_abs = ry_q[RAY_W-1] ? RAY_W'(0) - $unsigned(ry_q) : $unsigned(ry_q);
	assign perp   = side_q ? sdy_q - DS_W'(dy_q) : sdx_q - DS_W'(dx_q);

	always_comb begin
		case (cmd.div_sel)
			gdrc_pkg::DIV_DX: begin
				div_num = RECIP_NUM;
				div_den = DW'(rx_abs);
			end
			gdrc_pkg::DIV_DY: begin
				div_num = RECIP_NUM;
				div_den = DW'(ry_abs);
			end
			default: begin
				div_num = LH_NUM;
				div_den = perp;
			end
		endcase
	end

	gdrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quot)
	);

	// distance from the position to the first cell border, times delta
	assign opx = negx_q ? {1'b0, cfg.pos_x[FR_W-1:0]}
		: (FR_W+1)'(1 << FR_W) - {1'b0, cfg.pos_x[FR_W-1:0]};
	assign opy = negy_q ? {1'b0, cfg.pos_y[FR_W-1:0]}
		: (FR_W+1)'(1 << FR_W) - {1'b0, cfg.pos_y[FR_W-1:0]};
	assign spx = SP_W'(opx) * SP_W'(dx_q);
	assign spy = SP_W'(opy) * SP_W'(dy_q);

	// cells outside the map count as walls; start cell is never tested
	assign off_map = mx_q[CELL_W-1] || my_q[CELL_W-1]
		|| (mx_q >= CELL_W'(MAP_SIZE)) || (my_q >= CELL_W'(MAP_SIZE));
	assign hit_c = (n_q != '0)
		&& (off_map || cfg.map_walls[{mx_q[MI_W-1:0], my_q[MI_W-1:0]}]);

	assign sts.div_done = div_done;
	assign sts.walk_end = hit_c || (n_q == STEP_LIMIT);
	assign sts.hit      = hit_c;

	assign half   = lh_q >> 1;
	assign ds_c   = (half >= HALF_H) ? '0 : HALF_H - half;
	assign de_sum = half + HALF_H;
	assign de_c   = (de_sum >= ROWS) ? LAST_ROW : de_sum;

	always_ff @(posedge clk) begin
		if (cmd.load)
			col_q <= column;
		if (cmd.cam_calc)
			cam_q <= CAM_W'(cam_prod >> CAM_SH) - CAM_W'(gdrc_pkg::CAM_ONE);
		if (div_done) begin
			case (cmd.div_sel)
				gdrc_pkg::DIV_DX:  dx_q <= (rx_abs == '0) ? gdrc_pkg::DELTA_SAT : quot;
				gdrc_pkg::DIV_DY:  dy_q <= (ry_abs == '0) ? gdrc_pkg::DELTA_SAT : quot;
				default:           lh_q <= (perp == '0) ? LH_FULL : quot;
			endcase
		end
		if (cmd.ray_mul) begin
			prodx_q <= $signed(cfg.plane_x) * $signed(cam_q);
			prody_q <= $signed(cfg.plane_y) * $signed(cam_q);
		end
		if (cmd.ray_add) begin
			rx_q <= RAY_W'($signed(cfg.dir_x) + (prodx_q >>> 14));
			ry_q <= RAY_W'($signed(cfg.dir_y) + (prody_q >>> 14));
		end
		if (cmd.ray_add) begin
			negx_q <= 1'b0;
			negy_q <= 1'b0;
		end
		if (cmd.side_mul) begin
			sdx_q <= DS_W'(spx >> FR_W);
			sdy_q <= DS_W'(spy >> FR_W);
			mx_q  <= CELL_W'(cfg.pos_x[15:FR_W]);
			my_q  <= CELL_W'(cfg.pos_y[15:FR_W]);
			n_q   <= '0;
			side_q <= 1'b0;
		end
		if (cmd.walk_step) begin
			// ties step the y axis
			if (sdx_q < sdy_q) begin
				sdx_q  <= sdx_q + DS_W'(dx_q);
				mx_q   <= negx_q ? mx_q - CELL_W'(1) : mx_q + CELL_W'(1);
				side_q <= 1'b0;
			end else begin
				sdy_q  <= sdy_q + DS_W'(dy_q);
				my_q   <= negy_q ? my_q - CELL_W'(1) : my_q + CELL_W'(1);
				side_q <= 1'b1;
			end
			n_q <= n_q + STEP_W'(1);
		end
		if (cmd.div_start && cmd.div_sel == gdrc_pkg::DIV_DX) begin
			negx_q <= rx_q[RAY_W-1];
			negy_q <= ry_q[RAY_W-1];
		end
		if (cmd.finish) begin
			column_out <= col_q;
			wall_found <= hit_c;
			if (hit_c) begin
				draw_start <= ds_c[ROW_W-1:0];
				draw_end   <= de_c[ROW_W-1:0];
				wall_side  <= side_q;
				wall_shade <= side_q ? gdrc_pkg::SHADE_Y : gdrc_pkg::SHADE_X;
			end else begin
				draw_start <= '0;
				draw_end   <= '0;
				wall_side  <= 1'b0;
				wall_shade <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.finish;
	end

	assign done = done_q;
endmodule

FILE: design/gdrc_ctrl.sv
// Ray caster sequencer: orders the divisions, multiplies and the grid walk.
module gdrc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gdrc_pkg::sts_t sts,
	output gdrc_pkg::cmd_t cmd,
	output logic           busy
);
	gdrc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gdrc_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = gdrc_pkg::DIV_DX;
		unique case (state_q)
			gdrc_pkg::S_IDLE: begin
				cmd.load = start;
				if (start)
					state_d = gdrc_pkg::S_CAM;
			end
			gdrc_pkg::S_CAM: begin
				cmd.cam_calc = 1'b1;
				state_d = gdrc_pkg::S_RAY_MUL;
			end
			gdrc_pkg::S_RAY_MUL: begin
				cmd.ray_mul = 1'b1;
				state_d = gdrc_pkg::S_RAY_ADD;
			end
			gdrc_pkg::S_RAY_ADD: begin
				cmd.ray_add = 1'b1;
				state_d = gdrc_pkg::S_DX_GO;
			end
			gdrc_pkg::S_DX_GO: begin
				cmd.div_sel   = gdrc_pkg::DIV_DX;
				cmd.div_start = 1'b1;
				state_d = gdrc_pkg::S_DX_WAIT;
			end
			gdrc_pkg::S_DX_WAIT: begin
				cmd.div_sel = gdrc_pkg::DIV_DX;
				if (sts.div_done)
					state_d = gdrc_pkg::S_DY_GO;
			end
			gdrc_pkg::S_DY_GO: begin
				cmd.div_sel   = gdrc_pkg::DIV_DY;
				cmd.div_start = 1'b1;
				state_d = gdrc_pkg::S_DY_WAIT;
			end
			gdrc_pkg::S_DY_WAIT: begin
				cmd.div_sel = gdrc_pkg::DIV_DY;
				if (sts.div_done)
					state_d = gdrc_pkg::S_SIDE;
			end
			gdrc_pkg::S_SIDE: begin
				cmd.side_mul = 1'b1;
				state_d = gdrc_pkg::S_WALK;
			end
			gdrc_pkg::S_WALK: begin
				if (!sts.walk_end)
					cmd.walk_step = 1'b1;
				else if (sts.hit)
					state_d = gdrc_pkg::S_LH_GO;
				else
					state_d = gdrc_pkg::S_FIN;
			end
			gdrc_pkg::S_LH_GO: begin
				cmd.div_sel   = gdrc_pkg::DIV_LH;
				cmd.div_start = 1'b1;
				state_d = gdrc_pkg::S_LH_WAIT;
			end
			gdrc_pkg::S_LH_WAIT: begin
				cmd.div_sel = gdrc_pkg::DIV_LH;
				if (sts.div_done)
					state_d = gdrc_pkg::S_FIN;
			end
			gdrc_pkg::S_FIN: begin
				cmd.finish = 1'b1;
				state_d = gdrc_pkg::S_IDLE;
			end
			default: state_d = gdrc_pkg::S_IDLE;
		endcase
	end

	assign busy = state_q != gdrc_pkg::S_IDLE;
endmodule

FILE: design/gdrc_chk.sv
// Port-level checker for the ray caster, bound to the top level.
module gdrc_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [gdrc_pkg::ROW_W-1:0]      draw_start,
	input logic [gdrc_pkg::ROW_W-1:0]      draw_end,
	input logic                            wall_side,
	input logic [gdrc_pkg::SHADE_W-1:0]    wall_shade,
	input logic                            wall_found
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !wall_found |-> draw_start == '0 && draw_end == '0
			&& !wall_side && wall_shade == '0)
		else $error("miss result carries nonzero fields");

	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		done && wall_found |-> wall_shade ==
			(wall_side ? gdrc_pkg::SHADE_Y : gdrc_pkg::SHADE_X))
		else $error("shade does not match wall side");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && wall_found |-> draw_start <= draw_end)
		else $error("stripe top below bottom");
endmodule

bind grid_dda_column_raycaster_core gdrc_chk u_gdrc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.draw_start (draw_start),
	.draw_end   (draw_end),
	.wall_side  (wall_side),
	.wall_shade (wall_shade),
	.wall_found (wall_found)
);
